### sv/awgc_pkg.sv
// ----------------------------------------------------------------------------
// awgc_pkg
// Types, codes and helper functions shared by the gesture classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package awgc_pkg;

   // register indexes on the csr port
   localparam logic [1:0] REG_WINDOW_LEN      = 2'd0;
   localparam logic [1:0] REG_FORCE_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_ROLL_THRESHOLD  = 2'd2;
   localparam logic [1:0] REG_PITCH_THRESHOLD = 2'd3;

   localparam logic [5:0]         WINDOW_LEN_RST      = 6'd30;
   localparam logic [14:0]        FORCE_THRESHOLD_RST = 15'd512;
   localparam logic signed [11:0] ROLL_THRESHOLD_RST  = -12'sd600;
   localparam logic signed [11:0] PITCH_THRESHOLD_RST = 12'sd1000;

   // smallest usable window
   localparam int unsigned MIN_WINDOW = 2;

   typedef enum logic [2:0] {
      DIR_LEFT    = 3'd0,
      DIR_RIGHT   = 3'd1,
      DIR_UP      = 3'd2,
      DIR_DOWN    = 3'd3,
      DIR_WEAK    = 3'd4,
      DIR_NO_AXIS = 3'd5
   } dir_type;

   localparam logic [3:0] COMP_NONE       = 4'd0;
   localparam logic [3:0] COMP_DOWN_RIGHT = 4'd1;
   localparam logic [3:0] COMP_DOWN_LEFT  = 4'd2;
   localparam logic [3:0] COMP_UP_LEFT    = 4'd3;
   localparam logic [3:0] COMP_UP_RIGHT   = 4'd4;
   localparam logic [3:0] COMP_LEFT_UP    = 4'd5;
   localparam logic [3:0] COMP_RIGHT_UP   = 4'd6;
   localparam logic [3:0] COMP_LEFT_DOWN  = 4'd7;
   localparam logic [3:0] COMP_RIGHT_DOWN = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [5:0]         window_len;
      logic [14:0]        force_threshold;
      logic signed [11:0] roll_threshold;
      logic signed [11:0] pitch_threshold;
   } cfg_type;

   typedef struct packed {
      logic signed [11:0] pitch;
      logic signed [11:0] roll;
      logic signed [15:0] z;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } sample_type;

   typedef struct packed {
      logic store;   // write the item into the window
      logic start;   // evaluating item taken: clear peaks, latch compose flag
      logic rd_en;   // read one window entry for the peak scan
      logic decide;  // classify from the peaks and load the result
   } cmd_type;

   // magnitude of a 16-bit signed value, -32768 gives 32768
   function automatic logic [16:0] mag17(input logic signed [15:0] v);
      logic [16:0] ext;
      begin
         ext = {v[15], v};
         mag17 = v[15] ? (17'd0 - ext) : ext;
      end
   endfunction

   function automatic logic [3:0] pair_code(input dir_type a, input dir_type b);
      begin
         pair_code = COMP_NONE;
         if (a == DIR_DOWN && b == DIR_RIGHT) pair_code = COMP_DOWN_RIGHT;
         if (a == DIR_DOWN && b == DIR_LEFT)  pair_code = COMP_DOWN_LEFT;
         if (a == DIR_UP && b == DIR_LEFT)    pair_code = COMP_UP_LEFT;
         if (a == DIR_UP && b == DIR_RIGHT)   pair_code = COMP_UP_RIGHT;
         if (a == DIR_LEFT && b == DIR_UP)    pair_code = COMP_LEFT_UP;
         if (a == DIR_RIGHT && b == DIR_UP)   pair_code = COMP_RIGHT_UP;
         if (a == DIR_LEFT && b == DIR_DOWN)  pair_code = COMP_LEFT_DOWN;
         if (a == DIR_RIGHT && b == DIR_DOWN) pair_code = COMP_RIGHT_DOWN;
      end
   endfunction

endpackage

`default_nettype wire

### sv/accel_window_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// accel_window_gesture_classifier_core
// Windowed accelerometer gesture classifier with optional two-step compose.
// ----------------------------------------------------------------------------
// usage:
//  req_* carries one sample per item. while the window holds fewer than
//  window_len samples (clamped to 2..MAX_WINDOW) the item is written to the
//  window memory and taken, no result follows.
//  the next item is not stored; it starts an evaluation: the window memory
//  is read one entry a cycle through its single read port, a drain state
//  waits on the registered read and a decide state classifies; rsp_tvalid
//  rises in the resp state that follows.
//  the result stays in its output register while rsp_tready is low, and no
//  new item is taken until it is delivered.
//  csr_* writes a register; write only while the block idles.
//  reset (synchronous) empties the window, clears compose state and loads
//  the register defaults; stored samples are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_window_gesture_classifier_core #(
   parameter int unsigned MAX_WINDOW = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // force_x[15:0] force_y[31:16] force_z[47:32] roll_angle[59:48] pitch_angle[71:60]
   input  wire logic [71:0] req_tdata,
   // compose_held[0]
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // direction[2:0] composite[6:3] zero[7]
   output logic [7:0]       rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_wdata
);

   localparam int unsigned AW = $clog2(MAX_WINDOW);

   awgc_pkg::cfg_type    cfg;
   awgc_pkg::cmd_type    cmd;
   awgc_pkg::sample_type sample;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [2:0]           direction;
   logic [3:0]           composite;

   assign sample = req_tdata;

   awgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   awgc_ctrl #(.MAX_WINDOW(MAX_WINDOW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .window_len (cfg.window_len),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr)
   );

   awgc_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .sample       (sample),
      .compose_held (req_tuser[0]),
      .cmd          (cmd),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .direction    (direction),
      .composite    (composite)
   );

   assign rsp_tdata = {1'b0, composite, direction};

endmodule

`default_nettype wire

### sv/awgc_csr.sv
// ----------------------------------------------------------------------------
// awgc_csr
// Configuration registers written through the plain csr write port.
// ----------------------------------------------------------------------------
`default_nettype none

module awgc_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [14:0]      csr_wdata,
   output awgc_pkg::cfg_type     cfg
);

   awgc_pkg::cfg_type cfg_ff;
   awgc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            awgc_pkg::REG_WINDOW_LEN:      cfg_in.window_len      = csr_wdata[5:0];
            awgc_pkg::REG_FORCE_THRESHOLD: cfg_in.force_threshold = csr_wdata;
            awgc_pkg::REG_ROLL_THRESHOLD:  cfg_in.roll_threshold  = csr_wdata[11:0];
            awgc_pkg::REG_PITCH_THRESHOLD: cfg_in.pitch_threshold = csr_wdata[11:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_len      <= awgc_pkg::WINDOW_LEN_RST;
         cfg_ff.force_threshold <= awgc_pkg::FORCE_THRESHOLD_RST;
         cfg_ff.roll_threshold  <= awgc_pkg::ROLL_THRESHOLD_RST;
         cfg_ff.pitch_threshold <= awgc_pkg::PITCH_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### sv/awgc_ctrl.sv
// ----------------------------------------------------------------------------
// awgc_ctrl
// Sequencer: fills the window, walks it for the peak scan, hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module awgc_ctrl #(
   parameter int unsigned MAX_WINDOW = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [5:0]                    window_len,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output awgc_pkg::cmd_type                  cmd,
   output logic [$clog2(MAX_WINDOW)-1:0]      wr_addr,
   output logic [$clog2(MAX_WINDOW)-1:0]      rd_addr
);

   localparam int unsigned AW = $clog2(MAX_WINDOW);
   localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
   localparam int unsigned LW = (CW > 6) ? CW : 6;

   awgc_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic [LW-1:0] len;
   logic [LW-1:0] len_last;

   // clamp the window length into [MIN_WINDOW, MAX_WINDOW]
   always_comb begin
      len = LW'(window_len);
      if (len < LW'(awgc_pkg::MIN_WINDOW)) len = LW'(awgc_pkg::MIN_WINDOW);
      if (len > LW'(MAX_WINDOW))           len = LW'(MAX_WINDOW);
      len_last = len - LW'(1);
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         awgc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (LW'(count_ff) < len) begin
                  cmd.store = 1'b1;
                  count_in  = count_ff + CW'(1);
               end else begin
                  cmd.start = 1'b1;
                  count_in  = '0;
                  scan_in   = '0;
                  state_in  = awgc_pkg::ST_SCAN;
               end
            end
         end
         awgc_pkg::ST_SCAN: begin
            cmd.rd_en = 1'b1;
            scan_in   = scan_ff + AW'(1);
            if (scan_ff == len_last[AW-1:0]) state_in = awgc_pkg::ST_DRAIN;
         end
         // last read word is compared in this cycle
         awgc_pkg::ST_DRAIN: begin
            state_in = awgc_pkg::ST_DECIDE;
         end
         awgc_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = awgc_pkg::ST_RESP;
         end
         awgc_pkg::ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = awgc_pkg::ST_IDLE;
         end
         default: begin
            state_in = awgc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= awgc_pkg::ST_IDLE;
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
      end
   end

   assign wr_addr = count_ff[AW-1:0];
   assign rd_addr = scan_ff;

endmodule

`default_nettype wire

### sv/awgc_dp.sv
// ----------------------------------------------------------------------------
// awgc_dp
// Datapath: sample window memory, peak tracking, classification and compose.
// ----------------------------------------------------------------------------
`default_nettype none

module awgc_dp #(
   parameter int unsigned MAX_WINDOW = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire awgc_pkg::cfg_type             cfg,
   input  wire awgc_pkg::sample_type          sample,
   input  wire logic                          compose_held,
   input  wire awgc_pkg::cmd_type             cmd,
   input  wire logic [$clog2(MAX_WINDOW)-1:0] wr_addr,
   input  wire logic [$clog2(MAX_WINDOW)-1:0] rd_addr,
   output logic [2:0]                         direction,
   output logic [3:0]                         composite
);

   awgc_pkg::sample_type mem [MAX_WINDOW];
   awgc_pkg::sample_type rd_data_ff;
   logic                 rd_valid_ff;

   // running peaks, plus the fields of the sample that holds the x and z peaks
   logic [16:0]        mx_ff, my_ff, mz_ff;
   logic [16:0]        zx_ff;       // |z| of the x-peak sample
   logic signed [11:0] rollx_ff, pitchx_ff, rollz_ff, pitchz_ff;
   logic [16:0]        ax, ay, az;

   logic                held_ff;
   logic                compose_cnt_ff;
   awgc_pkg::dir_type   first_dir_ff;
   logic [2:0]          direction_ff;
   logic [3:0]          composite_ff;

   logic                x_dom, z_dom;
   logic [16:0]         sel_z;
   logic signed [11:0]  sel_roll, sel_pitch;
   awgc_pkg::dir_type   dir;

   always_ff @(posedge clock) begin
      if (cmd.store) mem[wr_addr] <= sample;
      if (cmd.rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else       rd_valid_ff <= cmd.rd_en;
   end

   assign ax = awgc_pkg::mag17(rd_data_ff.x);
   assign ay = awgc_pkg::mag17(rd_data_ff.y);
   assign az = awgc_pkg::mag17(rd_data_ff.z);

   // strict compare keeps the earliest index on a tie
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mx_ff   <= '0;
         my_ff   <= '0;
         mz_ff   <= '0;
         held_ff <= compose_held;
      end else if (rd_valid_ff) begin
         if (ax > mx_ff) begin
            mx_ff     <= ax;
            zx_ff     <= az;
            rollx_ff  <= rd_data_ff.roll;
            pitchx_ff <= rd_data_ff.pitch;
         end
         if (ay > my_ff) my_ff <= ay;
         if (az > mz_ff) begin
            mz_ff     <= az;
            rollz_ff  <= rd_data_ff.roll;
            pitchz_ff <= rd_data_ff.pitch;
         end
      end
   end

   always_comb begin
      x_dom     = (mx_ff > my_ff) && (mx_ff > mz_ff);
      z_dom     = (mz_ff > my_ff) && (mz_ff > mx_ff);
      sel_z     = x_dom ? zx_ff : mz_ff;
      sel_roll  = x_dom ? rollx_ff : rollz_ff;
      sel_pitch = x_dom ? pitchx_ff : pitchz_ff;
      if (sel_z < {2'b00, cfg.force_threshold}) begin
         dir = awgc_pkg::DIR_WEAK;
      end else if (sel_roll < cfg.roll_threshold) begin
         dir = (sel_pitch < cfg.pitch_threshold) ? awgc_pkg::DIR_LEFT : awgc_pkg::DIR_RIGHT;
      end else begin
         dir = (sel_pitch < cfg.pitch_threshold) ? awgc_pkg::DIR_UP : awgc_pkg::DIR_DOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compose_cnt_ff <= 1'b0;
         first_dir_ff   <= awgc_pkg::DIR_LEFT;
      end else if (cmd.decide && (x_dom || z_dom)) begin
         if (!held_ff) begin
            compose_cnt_ff <= 1'b0;
         end else if (!compose_cnt_ff) begin
            compose_cnt_ff <= 1'b1;
            first_dir_ff   <= dir;
         end else begin
            compose_cnt_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         if (!(x_dom || z_dom)) begin
            direction_ff <= awgc_pkg::DIR_NO_AXIS;
            composite_ff <= awgc_pkg::COMP_NONE;
         end else begin
            direction_ff <= dir;
            if (held_ff && compose_cnt_ff) composite_ff <= awgc_pkg::pair_code(first_dir_ff, dir);
            else                           composite_ff <= awgc_pkg::COMP_NONE;
         end
      end
   end

   assign direction = direction_ff;
   assign composite = composite_ff;

endmodule

`default_nettype wire

### test/accel_window_gesture_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// accel_window_gesture_classifier_core_tb
// Self-checking bench for the windowed gesture classifier. Samples are streamed
// in with random gaps and results are drained with random back-pressure; a
// gesture checker class tracks the window, the peak scan, the classification
// and the compose pairing, and compares every delivered result in order.
// ----------------------------------------------------------------------------
module accel_window_gesture_classifier_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WINDOW_DEPTH = 32;
   localparam int unsigned DRAIN_CYCLES = WINDOW_DEPTH + 8;
   localparam int unsigned PHASE_ITEMS  = 95;
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   typedef struct {
      awgc_pkg::dir_type dir;
      logic [3:0]        comp;
   } gesture_result_type;

   // ------------------------------------------------------------------------
   class gesture_checker_type;
      logic [5:0]           win_len;
      logic [14:0]          force_thr;
      logic signed [11:0]   roll_thr;
      logic signed [11:0]   pitch_thr;
      int unsigned          fill;
      awgc_pkg::sample_type window_mem [WINDOW_DEPTH];
      bit                   pair_open;
      awgc_pkg::dir_type    first_dir;
      gesture_result_type   gestures_due [$];
      int                   errors;

      function new();
         win_len   = awgc_pkg::WINDOW_LEN_RST;
         force_thr = awgc_pkg::FORCE_THRESHOLD_RST;
         roll_thr  = awgc_pkg::ROLL_THRESHOLD_RST;
         pitch_thr = awgc_pkg::PITCH_THRESHOLD_RST;
         fill      = 0;
         pair_open = 1'b0;
         first_dir = awgc_pkg::DIR_LEFT;
         errors    = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [14:0] val);
         case (idx)
            awgc_pkg::REG_WINDOW_LEN:      win_len = val[5:0];
            awgc_pkg::REG_FORCE_THRESHOLD: force_thr = val;
            awgc_pkg::REG_ROLL_THRESHOLD:  roll_thr = val[11:0];
            awgc_pkg::REG_PITCH_THRESHOLD: pitch_thr = val[11:0];
            default: ;
         endcase
      endfunction

      function int unsigned span();
         if (win_len < awgc_pkg::MIN_WINDOW) return awgc_pkg::MIN_WINDOW;
         if (win_len > WINDOW_DEPTH) return WINDOW_DEPTH;
         return win_len;
      endfunction

      function int unsigned pending();
         return gestures_due.size();
      endfunction

      static function int unsigned magnitude(logic signed [15:0] v);
         int w;
         w = v;
         return (w < 0) ? -w : w;
      endfunction

      static function logic [3:0] pair_gesture(awgc_pkg::dir_type a,
                                               awgc_pkg::dir_type b);
         case ({a, b})
            {awgc_pkg::DIR_DOWN, awgc_pkg::DIR_RIGHT}: return awgc_pkg::COMP_DOWN_RIGHT;
            {awgc_pkg::DIR_DOWN, awgc_pkg::DIR_LEFT}:  return awgc_pkg::COMP_DOWN_LEFT;
            {awgc_pkg::DIR_UP, awgc_pkg::DIR_LEFT}:    return awgc_pkg::COMP_UP_LEFT;
            {awgc_pkg::DIR_UP, awgc_pkg::DIR_RIGHT}:   return awgc_pkg::COMP_UP_RIGHT;
            {awgc_pkg::DIR_LEFT, awgc_pkg::DIR_UP}:    return awgc_pkg::COMP_LEFT_UP;
            {awgc_pkg::DIR_RIGHT, awgc_pkg::DIR_UP}:   return awgc_pkg::COMP_RIGHT_UP;
            {awgc_pkg::DIR_LEFT, awgc_pkg::DIR_DOWN}:  return awgc_pkg::COMP_LEFT_DOWN;
            {awgc_pkg::DIR_RIGHT, awgc_pkg::DIR_DOWN}: return awgc_pkg::COMP_RIGHT_DOWN;
            default:                                   return awgc_pkg::COMP_NONE;
         endcase
      endfunction

      // accepted item: store it, or scan the window and queue the gesture
      function void take_sample(awgc_pkg::sample_type s, bit held);
         int unsigned       len, i, k, ix, iz, mx, my, mz, ax, ay, az;
         awgc_pkg::dir_type d;
         logic [3:0]        comp;
         len = span();
         if (fill < len) begin
            window_mem[fill] = s;
            fill++;
            return;
         end
         ix = 0;
         iz = 0;
         mx = magnitude(window_mem[0].x);
         my = magnitude(window_mem[0].y);
         mz = magnitude(window_mem[0].z);
         for (i = 1; i < len; i++) begin
            ax = magnitude(window_mem[i].x);
            ay = magnitude(window_mem[i].y);
            az = magnitude(window_mem[i].z);
            if (ax > mx) begin
               mx = ax;
               ix = i;
            end
            if (ay > my) my = ay;
            if (az > mz) begin
               mz = az;
               iz = i;
            end
         end
         fill = 0;
         if (mx > my && mx > mz) k = ix;
         else if (mz > my && mz > mx) k = iz;
         else begin
            // no dominant axis leaves the compose pairing untouched
            gestures_due.push_back('{awgc_pkg::DIR_NO_AXIS, awgc_pkg::COMP_NONE});
            return;
         end
         if (magnitude(window_mem[k].z) < force_thr) d = awgc_pkg::DIR_WEAK;
         else if ($signed(window_mem[k].roll) < $signed(roll_thr))
            d = ($signed(window_mem[k].pitch) < $signed(pitch_thr)) ?
                awgc_pkg::DIR_LEFT : awgc_pkg::DIR_RIGHT;
         else
            d = ($signed(window_mem[k].pitch) < $signed(pitch_thr)) ?
                awgc_pkg::DIR_UP : awgc_pkg::DIR_DOWN;
         comp = awgc_pkg::COMP_NONE;
         if (held) begin
            if (!pair_open) begin
               first_dir = d;
               pair_open = 1'b1;
            end else begin
               comp = pair_gesture(first_dir, d);
               pair_open = 1'b0;
            end
         end else begin
            pair_open = 1'b0;
         end
         gestures_due.push_back('{d, comp});
      endfunction

      function void match_result(logic [7:0] data);
         gesture_result_type want;
         if (gestures_due.size() == 0) begin
            $display("%0t: unexpected result %h, expected none", $time, data);
            errors++;
            return;
         end
         want = gestures_due.pop_front();
         if (data[2:0] !== want.dir) begin
            $display("%0t: direction expected %0d actual %0d", $time, want.dir, data[2:0]);
            errors++;
         end
         if (data[6:3] !== want.comp) begin
            $display("%0t: composite expected %0d actual %0d", $time, want.comp, data[6:3]);
            errors++;
         end
         if (data[7] !== 1'b0) begin
            $display("%0t: pad bit expected 0 actual %b", $time, data[7]);
            errors++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // force_x, force_y, force_z, roll_angle, pitch_angle
   logic [0:0]  req_tuser = '0;   // compose_held
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // direction, composite, zero pad
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = awgc_pkg::REG_WINDOW_LEN;
   logic [14:0] csr_wdata = '0;

   gesture_checker_type sb;
   bit                  quiet = 1'b0;
   int unsigned         ready_hold = 0;
   int unsigned         cycles = 0;

   // window plan for the random part
   int                   peak_at;
   int                   tie_at;
   awgc_pkg::sample_type peak_item;
   awgc_pkg::sample_type tie_item;

   accel_window_gesture_classifier_core #(
      .MAX_WINDOW(WINDOW_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int near(int c, int spread, int lo, int hi);
      int v;
      v = c + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic int angle();
      return int'($urandom_range(0, 3600)) - 1800;
   endfunction

   function automatic awgc_pkg::sample_type calm_sample();
      awgc_pkg::sample_type s;
      s.x     = 16'(int'($urandom_range(0, 8000)) - 4000);
      s.y     = 16'(int'($urandom_range(0, 8000)) - 4000);
      s.z     = 16'(int'($urandom_range(0, 8000)) - 4000);
      s.roll  = 12'(angle());
      s.pitch = 12'(angle());
      return s;
   endfunction

   function automatic awgc_pkg::sample_type noise_sample();
      awgc_pkg::sample_type s;
      s.x     = 16'($urandom());
      s.y     = 16'($urandom());
      s.z     = 16'($urandom());
      s.roll  = 12'(angle());
      s.pitch = 12'(angle());
      return s;
   endfunction

   // one sample that should win the scan on a chosen axis
   function automatic awgc_pkg::sample_type build_peak();
      awgc_pkg::sample_type s;
      int kind, pk, zm;
      s = calm_sample();
      pk = $urandom_range(6000, 32768);
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         s.x = 16'($urandom_range(0, 1) ? -pk : pk);
         if ($urandom_range(0, 1)) zm = near(int'(sb.force_thr), 8, 0, 5999);
         else zm = $urandom_range(0, 5999);
         s.z = 16'($urandom_range(0, 1) ? -zm : zm);
      end else if (kind < 8) begin
         if ($urandom_range(0, 2) == 0) pk = near(int'(sb.force_thr), 3, 6000, 32768);
         s.z = 16'($urandom_range(0, 1) ? -pk : pk);
      end else if (kind == 8) begin
         s.y = 16'($urandom_range(0, 1) ? -pk : pk);
      end else begin
         // x and z level: nothing dominates
         s.x = 16'($urandom_range(0, 1) ? -pk : pk);
         s.z = 16'($urandom_range(0, 1) ? -pk : pk);
      end
      if ($urandom_range(0, 1)) s.roll = 12'(near(int'(sb.roll_thr), 2, -1800, 1800));
      if ($urandom_range(0, 1)) s.pitch = 12'(near(int'(sb.pitch_thr), 2, -1800, 1800));
      return s;
   endfunction

   task automatic next_item(output awgc_pkg::sample_type s, output bit held);
      int unsigned len, f;
      len = sb.span();
      f = sb.fill;
      held = $urandom_range(0, 1);
      if (f >= len) begin
         held = ($urandom_range(0, 9) < 7);
         s = $urandom_range(0, 1) ? noise_sample() : calm_sample();
      end else begin
         if (f == 0) begin
            peak_at = $urandom_range(0, len - 1);
            tie_at = -1;
            if ($urandom_range(0, 4) == 0) tie_at = $urandom_range(0, len - 1);
            peak_item = build_peak();
            // same magnitudes on every axis, other angles
            tie_item = peak_item;
            tie_item.x = -peak_item.x;
            tie_item.z = -peak_item.z;
            tie_item.roll = 12'(angle());
            tie_item.pitch = 12'(angle());
         end
         if ($urandom_range(0, 99) < 8) s = noise_sample();
         else if (f == peak_at) s = peak_item;
         else if (f == tie_at) s = tie_item;
         else s = calm_sample();
      end
   endtask

   // entered and left at a falling edge
   task automatic send_item(input awgc_pkg::sample_type s, input bit held);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tuser  <= held;
      do @(posedge clock); while (!req_tready);
      sb.take_sample(s, held);
      @(negedge clock);
   endtask

   task automatic send_fields(input int x, y, z, roll, pitch, input bit held);
      awgc_pkg::sample_type s;
      s.x     = 16'(x);
      s.y     = 16'(y);
      s.z     = 16'(z);
      s.roll  = 12'(roll);
      s.pitch = 12'(pitch);
      send_item(s, held);
   endtask

   task automatic put_reg(input logic [1:0] idx, input logic [14:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic load_regs(input int wl, ft, rt, pt, input bit len_only);
      put_reg(awgc_pkg::REG_WINDOW_LEN, 15'(wl));
      if (!len_only) begin
         put_reg(awgc_pkg::REG_FORCE_THRESHOLD, 15'(ft));
         put_reg(awgc_pkg::REG_ROLL_THRESHOLD, 15'(rt));
         put_reg(awgc_pkg::REG_PITCH_THRESHOLD, 15'(pt));
      end
      csr_we <= 1'b0;
   endtask

   // wait until every gesture is out and the block has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold = ready_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         ready_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.match_result(rsp_tdata);
   end

   initial begin
      logic [5:0]           len_plan [14];
      awgc_pkg::sample_type s;
      bit                   held;
      int                   ph, ft, rt, pt;
      sb = new();
      len_plan = '{6'd30, 6'd2, 6'd0, 6'd1, 6'd3, 6'd63, 6'd4,
                   6'd32, 6'd5, 6'd33, 6'd2, 6'd6, 6'd8, 6'd7};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed windows of two, thresholds still at their reset values
      load_regs(2, 0, 0, 0, 1'b1);
      // full-scale values, -32768 wins x; left, opens a compose pair
      send_fields(-32768, 0, 600, -1800, -1800, 1'b0);
      send_fields(32767, 32767, -32767, 1800, 1800, 1'b0);
      send_fields(0, 0, 0, 0, 0, 1'b1);
      // z tie goes to the first sample: down; compose released
      send_fields(10, -10, -3000, 0, 1800, 1'b1);
      send_fields(0, 0, 3000, -1800, -1800, 1'b0);
      send_fields(0, 0, 0, 0, 0, 1'b0);
      // down again as the first of a pair
      send_fields(10, -10, -3000, 0, 1800, 1'b0);
      send_fields(0, 0, 3000, -1800, -1800, 1'b1);
      send_fields(0, 0, 0, 0, 0, 1'b1);
      // y dominates: no axis, pair kept
      send_fields(32767, -32768, 32767, 0, 0, 1'b1);
      send_fields(0, 0, 0, 0, 0, 1'b0);
      send_fields(0, 0, 0, 0, 0, 1'b0);
      // right with roll just past and pitch at its threshold closes down-right
      send_fields(0, 0, 0, 0, 0, 1'b0);
      send_fields(20000, 5, -800, -601, 1000, 1'b0);
      send_fields(0, 0, 0, 0, 0, 1'b1);
      // weak z by one count, first of a pair
      send_fields(-9000, 0, 511, 1800, -1800, 1'b0);
      send_fields(0, 0, 0, 0, 0, 1'b0);
      send_fields(0, 0, 0, 0, 0, 1'b1);
      // up with roll at the threshold; weak then up names no gesture
      send_fields(0, 0, -32768, -600, 999, 1'b0);
      send_fields(0, 0, 0, 0, 0, 1'b0);
      send_fields(0, 0, 0, 0, 0, 1'b1);
      settle();
      // window cut short while three samples are held
      load_regs(5, 0, 0, 0, 1'b1);
      send_fields(0, 0, 700, 100, -100, 1'b0);
      send_fields(0, 0, 0, 0, 0, 1'b1);
      send_fields(0, 0, 0, 0, 0, 1'b0);
      settle();
      load_regs(2, 0, 0, 0, 1'b1);
      send_fields(0, 0, 0, 0, 0, 1'b0);

      for (ph = 0; ph < 14; ph++) begin
         settle();
         if ($urandom_range(0, 3) == 0) ft = $urandom_range(0, 32767);
         else ft = $urandom_range(0, 4000);
         rt = angle();
         pt = angle();
         case (ph)
            1: ft = 0;
            5: ft = 32767;
            2: begin
               rt = -1800;
               pt = 1800;
            end
            3: begin
               rt = 1800;
               pt = -1800;
            end
            default: ;
         endcase
         load_regs(len_plan[ph], ft, rt, pt, 1'b0);
         quiet = (ph % 4 == 3);
         repeat (PHASE_ITEMS) begin
            next_item(s, held);
            send_item(s, held);
         end
      end
      quiet = 1'b0;
      settle();

      if (sb.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
sv/awgc_pkg.sv
sv/awgc_csr.sv
sv/awgc_ctrl.sv
sv/awgc_dp.sv
sv/accel_window_gesture_classifier_core.sv
test/accel_window_gesture_classifier_core_tb.sv
